[src/rdpd_pkg.sv]
// ----------------------------------------------------------------------------
// rdpd_pkg: shared types and constants
// Item layouts, register indexes and reset values for the rotary dial
// pulse decoder.
// ----------------------------------------------------------------------------
package rdpd_pkg;

	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [CFG_IDX_W-1:0] REG_HOOK_GUARD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PULSE_MIN  = 2'd1;

	localparam logic [CFG_DATA_W-1:0] RESET_HOOK_GUARD = 16'd200;
	localparam logic [CFG_DATA_W-1:0] RESET_PULSE_MIN  = 16'd40;

	localparam logic [3:0] MAX_DIGIT_PULSES = 4'd10;
	localparam logic [3:0] COUNT_MAX        = 4'd15;

	typedef struct packed {
		logic [31:0] now_ms;
		logic        hook_level;
		logic        dial_level;
		logic        pulse_level;
	} in_item_t;

	typedef struct packed {
		logic       handset_down;
		logic       dial_busy;
		logic       digit_valid;
		logic [3:0] digit;
		logic       too_many_pulses;
	} out_item_t;

	typedef struct packed {
		logic [CFG_DATA_W-1:0] hook_guard_ms;
		logic [CFG_DATA_W-1:0] pulse_min_ms;
	} cfg_regs_t;

endpackage

[src/rdpd_cfg.sv]
// ----------------------------------------------------------------------------
// rdpd_cfg: configuration registers
// Holds the hook guard time and the minimum pulse time. Writes to an
// unknown index are dropped.
// ----------------------------------------------------------------------------
module rdpd_cfg (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [rdpd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rdpd_pkg::CFG_DATA_W-1:0] cfg_data,
	output rdpd_pkg::cfg_regs_t             regs
);

	rdpd_pkg::cfg_regs_t regs_q;

	assign cfg_ready = 1'b1;
	assign regs      = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.hook_guard_ms <= rdpd_pkg::RESET_HOOK_GUARD;
			regs_q.pulse_min_ms  <= rdpd_pkg::RESET_PULSE_MIN;
		end else if (cfg_valid && cfg_ready) begin
			if (cfg_index == rdpd_pkg::REG_HOOK_GUARD) begin
				regs_q.hook_guard_ms <= cfg_data;
			end else if (cfg_index == rdpd_pkg::REG_PULSE_MIN) begin
				regs_q.pulse_min_ms <= cfg_data;
			end
		end
	end

endmodule

[src/rdpd_core.sv]
// ----------------------------------------------------------------------------
// rdpd_core: decoder state and per-tick update
// Hook tracking with guard time, dial start and end detection, pulse
// counting and digit formation, all in one pass per sample tick.
// ----------------------------------------------------------------------------
module rdpd_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step,
	input  rdpd_pkg::in_item_t   item,
	input  rdpd_pkg::cfg_regs_t  regs,
	output rdpd_pkg::out_item_t  result
);

	logic        handset_q;
	logic [31:0] hook_time_q;
	logic        dialing_q;
	logic        awaiting_q;
	logic [3:0]  count_q;
	logic [31:0] pulse_time_q;

	logic        handset_d;
	logic [31:0] hook_time_d;
	logic        dialing_d;
	logic        awaiting_d;
	logic [3:0]  count_d;
	logic [31:0] pulse_time_d;

	logic [31:0] hook_age;
	logic [31:0] pulse_age;
	logic        turning;
	logic        released;

	assign hook_age  = item.now_ms - hook_time_q;
	assign pulse_age = item.now_ms - pulse_time_q;
	assign turning   = !item.dial_level;
	assign released  = item.pulse_level;

	always_comb begin
		handset_d    = item.hook_level;
		hook_time_d  = hook_time_q;
		dialing_d    = dialing_q;
		awaiting_d   = awaiting_q;
		count_d      = count_q;
		pulse_time_d = pulse_time_q;
		result       = '0;

		// An accepted hook change drops the dial in progress.
		if ((item.hook_level != handset_q) && (hook_age > {16'd0, regs.hook_guard_ms})) begin
			dialing_d   = 1'b0;
			count_d     = '0;
			hook_time_d = item.now_ms;
		end

		if (!turning && dialing_d) begin
			dialing_d = 1'b0;
			if ((count_d != '0) && (count_d <= rdpd_pkg::MAX_DIGIT_PULSES)) begin
				result.digit_valid = 1'b1;
				result.digit       = rdpd_pkg::MAX_DIGIT_PULSES - count_d;
				count_d            = '0;
			end else if (count_d > rdpd_pkg::MAX_DIGIT_PULSES) begin
				// The count is kept and carries into the next dialing.
				result.too_many_pulses = 1'b1;
			end
		end else if (turning && !dialing_d) begin
			dialing_d  = 1'b1;
			awaiting_d = 1'b1;
		end

		if (dialing_d) begin
			if (awaiting_d) begin
				if (released && (pulse_age > {16'd0, regs.pulse_min_ms})) begin
					if (count_d < rdpd_pkg::COUNT_MAX) begin
						count_d = count_d + 4'd1;
					end
					awaiting_d = 1'b0;
				end
			end else if (!released) begin
				pulse_time_d = item.now_ms;
				awaiting_d   = 1'b1;
			end
		end

		result.handset_down = handset_d;
		result.dial_busy    = dialing_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			handset_q    <= 1'b0;
			hook_time_q  <= '0;
			dialing_q    <= 1'b0;
			awaiting_q   <= 1'b0;
			count_q      <= '0;
			pulse_time_q <= '0;
		end else if (step) begin
			handset_q    <= handset_d;
			hook_time_q  <= hook_time_d;
			dialing_q    <= dialing_d;
			awaiting_q   <= awaiting_d;
			count_q      <= count_d;
			pulse_time_q <= pulse_time_d;
		end
	end

	a_digit_excl: assert property (@(posedge clk) disable iff (!arst_n)
		step && result.digit_valid |-> !result.too_many_pulses)
		else $error("digit and too-many flag raised on the same tick");

	a_digit_clears: assert property (@(posedge clk) disable iff (!arst_n)
		step && result.digit_valid |=> count_q == '0 && !dialing_q)
		else $error("pulse count not cleared after a digit");

	a_overflow_kept: assert property (@(posedge clk) disable iff (!arst_n)
		step && result.too_many_pulses |=> count_q == $past(count_q) && !dialing_q)
		else $error("pulse count lost after too many pulses");

	a_hold_idle: assert property (@(posedge clk) disable iff (!arst_n)
		!step |=> $stable(count_q) && $stable(dialing_q) && $stable(hook_time_q))
		else $error("decoder state moved without a tick");

endmodule

[src/rotary_dial_pulse_decoder_unit.sv]
// ----------------------------------------------------------------------------
// rotary_dial_pulse_decoder_unit: rotary dial pulse decoder
// Turns sampled hook, dial and pulse contact levels into handset state and
// dialed digits.
// ----------------------------------------------------------------------------
// Channel  Direction  Handshake             Payload
// in       input      in_valid / in_stall   in_item (time and pin levels)
// out      output     out_valid / out_stall out_item (state, digit, error)
// cfg      input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// One item per cycle is sustained while the output is not stalled; an item
// passes into the input register when it is taken and then into the result
// register, from which its result is on the output.
// Reset clears the decoder state and loads the default register values.
// A stalled result holds the input register; the input stalls only when
// both registers are full and the result is stalled.
// ----------------------------------------------------------------------------
module rotary_dial_pulse_decoder_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  rdpd_pkg::in_item_t              in_item,
	output logic                            out_valid,
	input  logic                            out_stall,
	output rdpd_pkg::out_item_t             out_item,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [rdpd_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [rdpd_pkg::CFG_DATA_W-1:0] cfg_data
);

	rdpd_pkg::in_item_t  item_s1;
	logic                valid_s1;
	rdpd_pkg::out_item_t out_q;
	logic                out_valid_q;
	rdpd_pkg::out_item_t result;
	rdpd_pkg::cfg_regs_t regs;
	logic                advance;
	logic                accept;

	assign advance   = valid_s1 && (!out_valid_q || !out_stall);
	assign in_stall  = valid_s1 && !advance;
	assign accept    = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	rdpd_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.regs      (regs)
	);

	rdpd_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.regs   (regs),
		.result (result)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1 <= in_item;
		end
		if (advance) begin
			out_q <= result;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			valid_s1 <= accept || (valid_s1 && !advance);
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

[bench/tb_rotary_dial_pulse_decoder_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rotary_dial_pulse_decoder_unit: self-checking bench for the dial decoder
// Drives sample ticks of hook, dial and pulse levels through the input
// channel, predicts every result with an in-bench decoder model and checks
// each result field by field, over several timing limits and idling phases.
// ----------------------------------------------------------------------------
module tb_rotary_dial_pulse_decoder_unit;

	localparam int WATCHDOG_LIMIT = 3000;

	// Indexes past the end of the register file; writes to them are dropped.
	localparam logic [rdpd_pkg::CFG_IDX_W-1:0] REG_UNUSED_A = 2'd2;
	localparam logic [rdpd_pkg::CFG_IDX_W-1:0] REG_UNUSED_B = 2'd3;

	logic                            clk = 1'b0;
	logic                            arst_n;
	logic                            in_valid;
	logic                            in_stall;
	rdpd_pkg::in_item_t              in_item;
	logic                            out_valid;
	logic                            out_stall;
	rdpd_pkg::out_item_t             out_item;
	logic                            cfg_valid;
	logic                            cfg_ready;
	logic [rdpd_pkg::CFG_IDX_W-1:0]  cfg_index;
	logic [rdpd_pkg::CFG_DATA_W-1:0] cfg_data;

	// Decoder model state and its copy of the registers.
	logic [rdpd_pkg::CFG_DATA_W-1:0] p_guard;
	logic [rdpd_pkg::CFG_DATA_W-1:0] p_min_len;
	logic                            p_down;
	logic [31:0]                     p_hook_stamp;
	logic                            p_dialing;
	logic                            p_armed;
	logic [3:0]                      p_pulses;
	logic [31:0]                     p_pulse_stamp;

	rdpd_pkg::out_item_t decoder_reports[$];
	int unsigned         items_sent;
	int unsigned         mismatch_count;
	int unsigned         idle_cycles;
	int unsigned         send_idle_pct;
	int unsigned         stall_pct;
	logic [31:0]         clock_ms;
	logic                hook_now;

	rotary_dial_pulse_decoder_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_item  (out_item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #6 clk = ~clk;

	function automatic rdpd_pkg::out_item_t decode_tick(input rdpd_pkg::in_item_t it);
		rdpd_pkg::out_item_t r;
		logic                turning;
		logic                released;
		logic [31:0]         since_hook;
		logic [31:0]         since_pulse;
		r = '0;
		turning = ~it.dial_level;
		released = it.pulse_level;
		since_hook = it.now_ms - p_hook_stamp;
		// The handset state always follows the pin; only a change outside the
		// guard time clears the dial and restarts the guard.
		if (it.hook_level != p_down && since_hook > {16'd0, p_guard}) begin
			p_dialing = 1'b0;
			p_pulses = '0;
			p_hook_stamp = it.now_ms;
		end
		p_down = it.hook_level;
		if (!turning && p_dialing) begin
			p_dialing = 1'b0;
			if (p_pulses != 0 && p_pulses <= rdpd_pkg::MAX_DIGIT_PULSES) begin
				r.digit_valid = 1'b1;
				r.digit = rdpd_pkg::MAX_DIGIT_PULSES - p_pulses;
				p_pulses = '0;
			end else if (p_pulses > rdpd_pkg::MAX_DIGIT_PULSES) begin
				// The count is kept and carries into the next dialing.
				r.too_many_pulses = 1'b1;
			end
		end else if (turning && !p_dialing) begin
			p_dialing = 1'b1;
			p_armed = 1'b1;
		end
		if (p_dialing) begin
			since_pulse = it.now_ms - p_pulse_stamp;
			if (p_armed) begin
				if (released && since_pulse > {16'd0, p_min_len}) begin
					if (p_pulses < rdpd_pkg::COUNT_MAX)
						p_pulses = p_pulses + 4'd1;
					p_armed = 1'b0;
				end
			end else if (!released) begin
				p_pulse_stamp = it.now_ms;
				p_armed = 1'b1;
			end
		end
		r.handset_down = p_down;
		r.dial_busy = p_dialing;
		return r;
	endfunction

	// Picks a delay on either side of a limit, often right at its edge.
	function automatic logic [31:0] around(input logic [rdpd_pkg::CFG_DATA_W-1:0] lim);
		int unsigned l;
		l = lim;
		case ($urandom_range(0, 5))
			0: return l;
			1: return l + 1;
			2: return (l == 0) ? 0 : l - 1;
			default: return $urandom_range(0, 2 * l + 3);
		endcase
	endfunction

	always @(posedge clk) begin
		if (arst_n && in_valid && !in_stall)
			decoder_reports.push_back(decode_tick(in_item));
	end

	always @(posedge clk) begin : check_results
		rdpd_pkg::out_item_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (decoder_reports.size() == 0) begin
				$error("result with no item waiting: %p", out_item);
				mismatch_count++;
			end else begin
				want = decoder_reports.pop_front();
				if (out_item.handset_down !== want.handset_down) begin
					$error("handset_down: expected %0d, got %0d",
						want.handset_down, out_item.handset_down);
					mismatch_count++;
				end
				if (out_item.dial_busy !== want.dial_busy) begin
					$error("dial_busy: expected %0d, got %0d",
						want.dial_busy, out_item.dial_busy);
					mismatch_count++;
				end
				if (out_item.digit_valid !== want.digit_valid) begin
					$error("digit_valid: expected %0d, got %0d",
						want.digit_valid, out_item.digit_valid);
					mismatch_count++;
				end
				if (out_item.digit !== want.digit) begin
					$error("digit: expected %0d, got %0d", want.digit, out_item.digit);
					mismatch_count++;
				end
				if (out_item.too_many_pulses !== want.too_many_pulses) begin
					$error("too_many_pulses: expected %0d, got %0d",
						want.too_many_pulses, out_item.too_many_pulses);
					mismatch_count++;
				end
			end
		end
		out_stall <= ($urandom_range(0, 99) < stall_pct);
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
				(cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("** rotary_dial_pulse_decoder_unit: FAILED **");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic send_tick(input logic [31:0] now, input logic hook, input logic dial,
			input logic pulse);
		rdpd_pkg::in_item_t it;
		it.now_ms = now;
		it.hook_level = hook;
		it.dial_level = dial;
		it.pulse_level = pulse;
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_item <= it;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		clock_ms = now;
		items_sent++;
	endtask

	task automatic step(input logic [31:0] dt, input logic hook, input logic dial,
			input logic pulse);
		send_tick(clock_ms + dt, hook, dial, pulse);
	endtask

	task automatic wait_quiet();
		in_valid <= 1'b0;
		@(posedge clk);
		while (decoder_reports.size() != 0)
			@(posedge clk);
		// Items still in the pipeline have all reported.
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [rdpd_pkg::CFG_IDX_W-1:0] idx,
			input logic [rdpd_pkg::CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			rdpd_pkg::REG_HOOK_GUARD: p_guard = data;
			rdpd_pkg::REG_PULSE_MIN:  p_min_len = data;
			default: ;
		endcase
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic program_limits(input logic [rdpd_pkg::CFG_DATA_W-1:0] guard,
			input logic [rdpd_pkg::CFG_DATA_W-1:0] min_len);
		wait_quiet();
		write_reg(rdpd_pkg::REG_HOOK_GUARD, guard);
		write_reg(rdpd_pkg::REG_PULSE_MIN, min_len);
	endtask

	// One stretch of activity: mostly a whole dialed digit, sometimes hook
	// flapping or raw noise.
	task automatic dial_sequence();
		int unsigned kind;
		int unsigned n;
		int unsigned i;
		kind = $urandom_range(0, 99);
		if (kind < 70) begin
			if ($urandom_range(0, 3) == 0) begin
				hook_now = ~hook_now;
				step(around(p_guard), hook_now, 1'b1, 1'b1);
			end
			step($urandom_range(1, 50), hook_now, 1'b0, 1'($urandom_range(0, 1)));
			n = ($urandom_range(0, 4) == 0) ? $urandom_range(11, 17) : $urandom_range(1, 10);
			for (i = 0; i < n; i++) begin
				if ($urandom_range(0, 19) == 0)
					hook_now = ~hook_now;
				step($urandom_range(0, 20), hook_now, 1'b0, 1'b0);
				if ($urandom_range(0, 1) == 0)
					step({16'd0, p_min_len} + 1 + $urandom_range(0, 20), hook_now, 1'b0, 1'b1);
				else
					step(around(p_min_len), hook_now, 1'b0, 1'b1);
			end
			// Now and then the dial is left turning into the next sequence.
			step($urandom_range(1, 100), hook_now, ($urandom_range(0, 9) != 0), 1'b1);
		end else if (kind < 85) begin
			repeat ($urandom_range(2, 5)) begin
				hook_now = ~hook_now;
				step(around(p_guard), hook_now, 1'b1, 1'($urandom_range(0, 1)));
			end
		end else begin
			repeat ($urandom_range(1, 4)) begin
				send_tick(($urandom_range(0, 3) == 0) ? $urandom() :
					clock_ms + $urandom_range(0, 1000),
					1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
					1'($urandom_range(0, 1)));
			end
		end
	endtask

	task automatic run_burst(input int unsigned count);
		int unsigned stop_at;
		stop_at = items_sent + count;
		while (items_sent < stop_at)
			dial_sequence();
	endtask

	task automatic test_directed_cases();
		send_idle_pct = 0;
		stall_pct = 0;
		send_tick(32'd0,   1'b1, 1'b1, 1'b1);   // hook change inside the guard time
		send_tick(32'd150, 1'b0, 1'b1, 1'b1);
		send_tick(32'd300, 1'b1, 1'b1, 1'b1);   // accepted hook change
		send_tick(32'd400, 1'b1, 1'b0, 1'b1);   // dial starts with contact released
		send_tick(32'd410, 1'b1, 1'b0, 1'b0);
		send_tick(32'd440, 1'b1, 1'b0, 1'b1);   // too short to count
		send_tick(32'd451, 1'b1, 1'b0, 1'b1);
		send_tick(32'd460, 1'b1, 1'b1, 1'b1);   // two pulses make an eight
		send_tick(32'd500, 1'b1, 1'b0, 1'b0);
		send_tick(32'd520, 1'b1, 1'b1, 1'b0);   // dialing ends with no pulses
		send_tick(32'd600, 1'b1, 1'b0, 1'b1);
		send_tick(32'd650, 1'b0, 1'b0, 1'b1);   // hook change clears a running dial
		send_tick(32'd700, 1'b0, 1'b1, 1'b1);
		send_tick(32'hFFFF_FFF0, 1'b1, 1'b1, 1'b1);
		send_tick(32'h0000_0010, 1'b0, 1'b1, 1'b1);   // guard measured across the wrap
		send_tick(32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0);
		send_tick(32'h0000_0000, 1'b0, 1'b0, 1'b1);
		send_tick(32'h0000_0001, 1'b0, 1'b1, 1'b1);
		clock_ms = 32'd1;
		hook_now = 1'b0;
	endtask

	task automatic test_default_timing();
		program_limits(rdpd_pkg::RESET_HOOK_GUARD, rdpd_pkg::RESET_PULSE_MIN);
		send_idle_pct = 0;
		stall_pct = 0;
		run_burst(180);
	endtask

	task automatic test_zero_limits();
		program_limits(16'd0, 16'd0);
		send_idle_pct = 63;
		stall_pct = 0;
		run_burst(170);
	endtask

	task automatic test_max_limits();
		program_limits(16'hFFFF, 16'hFFFF);
		send_idle_pct = 0;
		stall_pct = 63;
		run_burst(170);
	endtask

	task automatic test_random_limits();
		program_limits(16'($urandom_range(0, 65535)), 16'($urandom_range(0, 120)));
		send_idle_pct = 7;
		stall_pct = 7;
		run_burst(170);
	endtask

	task automatic test_drain_pause();
		program_limits(16'($urandom_range(0, 400)), 16'($urandom_range(0, 80)));
		send_idle_pct = 0;
		stall_pct = 63;
		run_burst(90);
		// The sender holds off until every pending item has reported.
		in_valid <= 1'b0;
		@(posedge clk);
		while (decoder_reports.size() != 0)
			@(posedge clk);
		run_burst(90);
	endtask

	task automatic test_unused_indexes();
		program_limits(16'd123, 16'd17);
		write_reg(REG_UNUSED_A, 16'($urandom_range(0, 65535)));
		write_reg(REG_UNUSED_B, 16'hFFFF);
		send_idle_pct = 63;
		stall_pct = 0;
		run_burst(170);
	endtask

	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		in_item = '0;
		out_stall = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = rdpd_pkg::REG_HOOK_GUARD;
		cfg_data = '0;
		p_guard = rdpd_pkg::RESET_HOOK_GUARD;
		p_min_len = rdpd_pkg::RESET_PULSE_MIN;
		p_down = 1'b0;
		p_hook_stamp = '0;
		p_dialing = 1'b0;
		p_armed = 1'b0;
		p_pulses = '0;
		p_pulse_stamp = '0;
		items_sent = 0;
		mismatch_count = 0;
		idle_cycles = 0;
		send_idle_pct = 0;
		stall_pct = 0;
		clock_ms = '0;
		hook_now = 1'b0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_cases();
		test_default_timing();
		test_zero_limits();
		test_max_limits();
		test_random_limits();
		test_drain_pause();
		test_unused_indexes();

		in_valid <= 1'b0;
		@(posedge clk);
		while (decoder_reports.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatch_count == 0 && decoder_reports.size() == 0) begin
			$display("** rotary_dial_pulse_decoder_unit: PASSED **");
		end else begin
			$display("** rotary_dial_pulse_decoder_unit: FAILED **");
		end
		$finish;
	end

endmodule

[sim.f]
src/rdpd_pkg.sv
src/rdpd_cfg.sv
src/rdpd_core.sv
src/rotary_dial_pulse_decoder_unit.sv
bench/tb_rotary_dial_pulse_decoder_unit.sv
